// File: rtl/bloom_signature_build_and_probe_assert.svh
// Assertion macros for the Bloom signature block.
// Used by the datapath; relies on ports named clock and reset.
`ifndef BLOOM_SIGNATURE_BUILD_AND_PROBE_ASSERT_SVH
`define BLOOM_SIGNATURE_BUILD_AND_PROBE_ASSERT_SVH

// clocked check, off while reset is high
`define BSBP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds during reset
`define BSBP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/bsbp_pkg.sv
// Shared types and constants for the Bloom signature block.
// No dependencies.
package bsbp_pkg;

   localparam int MAX_SIG_BYTES = 256;
   localparam int SIG_AW = $clog2(MAX_SIG_BYTES);
   localparam int SB_W = $clog2(MAX_SIG_BYTES + 1);
   localparam int REM_W = $clog2(MAX_SIG_BYTES * 8);
   localparam int N_W = REM_W + 1;
   localparam int DIV_STEPS = 32;
   localparam int DC_W = $clog2(DIV_STEPS);
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [7:0] BYTE_FULL = 8'hFF;
   localparam logic [7:0] BYTE_ONE = 8'h01;
   localparam logic [SB_W-1:0] SIG_BYTES_RESET = SB_W'(16);

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_INSERT = 2'd2;
   localparam logic [1:0] KIND_QUERY = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [7:0] sig_index;
      logic has_byte;
      logic string_last;
      logic query_last;
      logic query_any;
   } req_type;

   typedef struct packed {
      logic is_query;
      logic match;
      logic all_ones;
   } rsp_type;

   typedef struct packed {
      logic latch;
      logic clear;
      logic wr_byte;
      logic crc_upd;
      logic crc_rst;
      logic div_load;
      logic div_step;
      logic rd_byte;
      logic modify;
      logic cfg_wr;
      logic cnt_clr;
      logic cnt_step;
      logic [SIG_AW-1:0] cnt_idx;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic string_last;
      logic query_last;
      logic rsp_free;
   } dp_stat_type;

endpackage

// File: rtl/bloom_signature_build_and_probe.sv
// Top level of the Bloom signature block: controller and datapath.
// Depends on bsbp_pkg, bsbp_ctrl and bsbp_dp.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall req_data (req_type)
//   rsp      out        rsp_valid/rsp_stall rsp_data (rsp_type)
//   csr      in         csr_valid/csr_ready csr_data (sig_bytes, 9 bits)
//
// A byte, clear or write item is accepted and then dispatched.
// A string end runs dispatch, 32 remainder steps, memory read, modify and
// result load, the last only when it gives a result; the result transfer waits while
// rsp_stall is high. A query end inside a string runs accept, dispatch, result load.
// A sig_bytes write starts a full-byte recount; no item is taken meanwhile.
// Reset is synchronous and clears the signature through per-byte valid bits.
module bloom_signature_build_and_probe import bsbp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [SB_W-1:0] csr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type stat;

   bsbp_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .stat(stat),
      .cmd(cmd)
   );

   bsbp_dp u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_data(req_data),
      .csr_data(csr_data),
      .rsp_data(rsp_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall)
   );

endmodule

// File: rtl/bsbp_dp.sv
// Datapath: CRC register, remainder divider, signature memory, full-byte count,
// query accumulator and result register. Uses bsbp_pkg and the assertion header.
`include "bloom_signature_build_and_probe_assert.svh"

module bsbp_dp import bsbp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  ctrl_cmd_type cmd,
   output dp_stat_type stat,
   input  req_type req_data,
   input  logic [SB_W-1:0] csr_data,
   output rsp_type rsp_data,
   output logic rsp_valid,
   input  logic rsp_stall
);

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

   logic [7:0] sig_mem [MAX_SIG_BYTES];

   req_type item_ff, item_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [7:0] rd_ff;
   logic rd_vld_ff, rd_vld_in;
   logic [MAX_SIG_BYTES-1:0] vld_ff, vld_in;
   logic [MAX_SIG_BYTES-1:0] full_ff, full_in;
   logic [SB_W-1:0] cnt_ff, cnt_in;
   logic [SB_W-1:0] sig_bytes_ff, sig_bytes_in;
   logic acc_ff, acc_in;
   logic open_ff, open_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [31:0] crc_nx;
   logic [N_W-1:0] div_n;
   logic [N_W-1:0] div_t;
   logic [SIG_AW-1:0] rem_addr;
   logic [SIG_AW-1:0] wb_addr;
   logic [7:0] byte_old;
   logic [7:0] byte_new;
   logic hit;
   logic base;
   logic wr_en;
   logic [SIG_AW-1:0] wr_addr;
   logic [7:0] wr_data;
   logic rsp_free;
   logic all_ones;

   assign div_n = N_W'(sig_bytes_ff) << 3;
   assign rem_addr = rem_ff[REM_W-1:3];
   assign wb_addr = SIG_AW'(item_ff.sig_index);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign all_ones = (cnt_ff == sig_bytes_ff);

   always_comb begin
      item_in = item_ff;
      crc_in = crc_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      rd_vld_in = rd_vld_ff;
      vld_in = vld_ff;
      full_in = full_ff;
      cnt_in = cnt_ff;
      sig_bytes_in = sig_bytes_ff;
      acc_in = acc_ff;
      open_in = open_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en = 1'b0;
      wr_addr = rem_addr;
      wr_data = 8'd0;
      crc_nx = item_ff.has_byte ? crc_byte(crc_ff, item_ff.data_byte) : crc_ff;
      div_t = {rem_ff, dvd_ff[31]};
      byte_old = rd_vld_ff ? rd_ff : 8'd0;
      byte_new = byte_old | (BYTE_ONE << rem_ff[2:0]);
      hit = byte_old[rem_ff[2:0]];
      base = open_ff ? acc_ff : !item_ff.query_any;

      if (cmd.latch) begin
         item_in = req_data;
      end
      if (cmd.crc_rst) begin
         crc_in = CRC_ONES;
      end else if (cmd.crc_upd) begin
         crc_in = crc_nx;
      end
      if (cmd.div_load) begin
         dvd_in = crc_nx ^ CRC_ONES;
         rem_in = '0;
      end
      if (cmd.div_step) begin
         dvd_in = dvd_ff << 1;
         if (div_t >= div_n) begin
            rem_in = REM_W'(div_t - div_n);
         end else begin
            rem_in = div_t[REM_W-1:0];
         end
      end
      if (cmd.rd_byte) begin
         rd_vld_in = vld_ff[rem_addr];
      end
      if (cmd.clear) begin
         vld_in = '0;
         full_in = '0;
         cnt_in = '0;
      end
      if (cmd.wr_byte && (SB_W'(item_ff.sig_index) < sig_bytes_ff)) begin
         wr_en = 1'b1;
         wr_addr = wb_addr;
         wr_data = item_ff.data_byte;
         vld_in[wb_addr] = 1'b1;
         full_in[wb_addr] = (item_ff.data_byte == BYTE_FULL);
         if ((item_ff.data_byte == BYTE_FULL) && !full_ff[wb_addr]) begin
            cnt_in = cnt_ff + SB_W'(1);
         end else if ((item_ff.data_byte != BYTE_FULL) && full_ff[wb_addr]) begin
            cnt_in = cnt_ff - SB_W'(1);
         end
      end
      if (cmd.modify) begin
         if (item_ff.kind == KIND_INSERT) begin
            wr_en = 1'b1;
            wr_data = byte_new;
            vld_in[rem_addr] = 1'b1;
            full_in[rem_addr] = (byte_new == BYTE_FULL);
            if ((byte_new == BYTE_FULL) && !full_ff[rem_addr]) begin
               cnt_in = cnt_ff + SB_W'(1);
            end
         end else begin
            acc_in = item_ff.query_any ? (base | hit) : (base & hit);
            open_in = 1'b1;
         end
      end
      if (cmd.cfg_wr) begin
         if (csr_data == '0) begin
            sig_bytes_in = SB_W'(1);
         end else if (csr_data > SB_W'(MAX_SIG_BYTES)) begin
            sig_bytes_in = SB_W'(MAX_SIG_BYTES);
         end else begin
            sig_bytes_in = csr_data;
         end
      end
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end
      if (cmd.cnt_step && full_ff[cmd.cnt_idx] && (SB_W'(cmd.cnt_idx) < sig_bytes_ff)) begin
         cnt_in = cnt_ff + SB_W'(1);
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in.is_query = (item_ff.kind == KIND_QUERY);
         rsp_in.match = (item_ff.kind == KIND_QUERY) ? base : 1'b0;
         rsp_in.all_ones = all_ones;
         if (item_ff.kind == KIND_QUERY) begin
            acc_in = 1'b0;
            open_in = 1'b0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sig_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_byte) begin
         rd_ff <= sig_mem[rem_addr];
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         crc_ff <= CRC_ONES;
         rd_vld_ff <= 1'b0;
         vld_ff <= '0;
         full_ff <= '0;
         cnt_ff <= '0;
         sig_bytes_ff <= SIG_BYTES_RESET;
         acc_ff <= 1'b0;
         open_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         rd_vld_ff <= rd_vld_in;
         vld_ff <= vld_in;
         full_ff <= full_in;
         cnt_ff <= cnt_in;
         sig_bytes_ff <= sig_bytes_in;
         acc_ff <= acc_in;
         open_ff <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.kind = item_ff.kind;
   assign stat.string_last = item_ff.string_last;
   assign stat.query_last = item_ff.query_last;
   assign stat.rsp_free = rsp_free;
   assign rsp_data = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   `BSBP_ASSERT(a_rem_range, cmd.modify |-> (N_W'(rem_ff) < div_n), "remainder out of range")
   `BSBP_ASSERT(a_rsp_slot, cmd.rsp_load |-> rsp_free, "result loaded over a pending transfer")
   `BSBP_ASSERT(a_cnt_bound, cnt_ff <= sig_bytes_ff, "full-byte count above signature length")

endmodule

// File: rtl/bsbp_ctrl.sv
// Controller: sequences dispatch, CRC remainder steps, memory read-modify-write,
// result transfer and the full-byte recount after a length write. Uses bsbp_pkg.
module bsbp_ctrl import bsbp_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic csr_valid,
   output logic csr_ready,
   input  dp_stat_type stat,
   output ctrl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_DIV = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_MOD = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;
   localparam logic [2:0] S_CNT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [DC_W-1:0] div_cnt_ff, div_cnt_in;
   logic [SIG_AW-1:0] sweep_ff, sweep_in;

   always_comb begin
      state_in = state_ff;
      div_cnt_in = div_cnt_ff;
      sweep_in = sweep_ff;
      cmd = '0;
      cmd.cnt_idx = sweep_ff;
      csr_ready = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            csr_ready = 1'b1;
            req_stall = csr_valid;
            if (csr_valid) begin
               cmd.cfg_wr = 1'b1;
               cmd.cnt_clr = 1'b1;
               sweep_in = '0;
               state_in = S_CNT;
            end else if (req_valid) begin
               cmd.latch = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            unique case (stat.kind)
               KIND_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in = S_IDLE;
               end
               KIND_WRITE: begin
                  cmd.wr_byte = 1'b1;
                  state_in = S_IDLE;
               end
               default: begin
                  cmd.crc_upd = 1'b1;
                  if (stat.string_last) begin
                     cmd.crc_rst = 1'b1;
                     cmd.div_load = 1'b1;
                     div_cnt_in = '0;
                     state_in = S_DIV;
                  end else if ((stat.kind == KIND_QUERY) && stat.query_last) begin
                     cmd.crc_rst = 1'b1;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in = div_cnt_ff + DC_W'(1);
            if (div_cnt_ff == DC_W'(DIV_STEPS - 1)) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_byte = 1'b1;
            state_in = S_MOD;
         end
         S_MOD: begin
            cmd.modify = 1'b1;
            if ((stat.kind == KIND_INSERT) || stat.query_last) begin
               state_in = S_RESP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_CNT: begin
            cmd.cnt_step = 1'b1;
            sweep_in = sweep_ff + SIG_AW'(1);
            if (sweep_ff == SIG_AW'(MAX_SIG_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         div_cnt_ff <= '0;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         div_cnt_ff <= div_cnt_in;
         sweep_ff <= sweep_in;
      end
   end

endmodule
